// ===== rtl/bmhq_pkg.sv =====
// Shared types and constants for the binary min-heap queue.
package bmhq_pkg;

    localparam int VAL_W          = 32;
    localparam int CNT_OUT_W      = 11;
    localparam int NODE_W         = 17;
    localparam int DEP_W          = 5;
    localparam int HEAP_DEPTH_DEF = 1024;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef struct packed {
        t_req                    req_type;
        logic signed [VAL_W-1:0] push_value;
    } t_req_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] min_value;
        logic [CNT_OUT_W-1:0]    entry_count;
        logic                    is_empty;
        logic                    op_error;
    } t_rsp_item;

    typedef enum logic [1:0] {
        OP_INS,
        OP_FETCH,
        OP_SIFT
    } t_op;

    // token handed from one level to the next
    typedef struct packed {
        logic                    act;
        t_op                     op;
        logic                    stop;
        logic [NODE_W-1:0]       node;
        logic [NODE_W-1:0]       tgt;
        logic [NODE_W-1:0]       lim;
        logic [DEP_W-1:0]        dep;
        logic signed [VAL_W-1:0] val;
    } t_tok;

    // write of the slot chosen one level up
    typedef struct packed {
        logic                    we;
        logic signed [VAL_W-1:0] val;
    } t_upw;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_FETCH,
        ST_SIFT,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/bmhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bmhq_ram
    import bmhq_pkg::*;
#(
    parameter int WIDTH = 2 * VAL_W,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bmhq_cell.sv =====
// One heap level: sibling-pair store plus the compare and swap for that level.
module bmhq_cell
    import bmhq_pkg::*;
#(
    parameter int   LVL  = 1,
    parameter logic LAST = 1'b0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok,
    input  t_upw i_upw,
    output t_upw o_upw
);

    localparam int PAIRS = 1 << (LVL - 1);
    localparam int PAW   = (LVL > 1) ? LVL - 1 : 1;

    t_tok                    r_tok;
    logic                    r_act;
    logic [2*VAL_W-1:0]      rd_pair;
    logic [2*VAL_W-1:0]      wr_pair;
    logic [PAW-1:0]          rd_addr;
    logic [PAW-1:0]          wr_addr;
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    logic signed [VAL_W-1:0] here_v;
    logic signed [VAL_W-1:0] pick_v;
    logic signed [VAL_W-1:0] wval;
    logic                    pick_r;
    logic                    left_ok;
    logic                    at_here;
    logic                    we;
    logic                    wsel;
    logic [DEP_W-1:0]        bit_idx;
    logic [NODE_W-1:0]       path_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= i_tok.act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.act) begin
            r_tok <= i_tok;
        end
    end

    assign rd_addr = (LVL > 1) ? PAW'(i_tok.node >> 1) : '0;
    assign wr_addr = (LVL > 1) ? PAW'(r_tok.node >> 1) : '0;

    assign left_v    = rd_pair[VAL_W-1:0];
    assign right_v   = rd_pair[2*VAL_W-1:VAL_W];
    assign here_v    = r_tok.node[0] ? right_v : left_v;
    assign left_ok   = r_tok.node <= r_tok.lim;
    assign pick_r    = (r_tok.node < r_tok.lim) && (right_v < left_v);
    assign pick_v    = pick_r ? right_v : left_v;
    assign at_here   = r_tok.dep == DEP_W'(LVL);
    assign bit_idx   = r_tok.dep - DEP_W'(LVL + 1);
    assign path_node = {r_tok.node[NODE_W-2:0], r_tok.tgt[bit_idx]};

    always_comb begin
        o_tok     = r_tok;
        o_tok.act = r_act;
        o_upw     = '0;
        we        = 1'b0;
        wsel      = r_tok.node[0];
        wval      = r_tok.val;
        if (r_act && !r_tok.stop) begin
            unique case (r_tok.op)
                OP_INS: begin
                    if (at_here) begin
                        we         = 1'b1;
                        o_tok.stop = 1'b1;
                    end else begin
                        o_tok.node = path_node;
                        if (r_tok.val < here_v) begin
                            we        = 1'b1;
                            o_tok.val = here_v;
                        end
                    end
                end
                OP_FETCH: begin
                    if (at_here) begin
                        o_tok.val  = here_v;
                        o_tok.stop = 1'b1;
                    end else begin
                        o_tok.node = path_node;
                    end
                end
                OP_SIFT: begin
                    if (left_ok && !(r_tok.val < pick_v)) begin
                        o_upw      = '{we: 1'b1, val: pick_v};
                        o_tok.node = {r_tok.node[NODE_W-2:1], pick_r, 1'b0};
                        if (LAST) begin
                            we   = 1'b1;
                            wsel = pick_r;
                        end
                    end else begin
                        o_upw      = '{we: 1'b1, val: r_tok.val};
                        o_tok.stop = 1'b1;
                    end
                end
                default: begin
                    o_tok.stop = 1'b1;
                end
            endcase
        end else if (i_upw.we) begin
            // child has settled the slot picked here on the previous cycle
            we   = 1'b1;
            wsel = pick_r;
            wval = i_upw.val;
        end
    end

    assign wr_pair = wsel ? {wval, left_v} : {right_v, wval};

    bmhq_ram #(
        .WIDTH(2 * VAL_W),
        .DEPTH(PAIRS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(wr_addr),
        .i_wdata(wr_pair),
        .i_re   (i_tok.act),
        .i_raddr(rd_addr),
        .o_rdata(rd_pair)
    );

endmodule

// ===== rtl/binary_min_heap_queue_top.sv =====
// Top level of the binary min-heap queue: root, sequencer and chain of level cells.
//
//  channel | dir | handshake                  | payload
//  request | in  | i_req_valid / o_req_ready  | i_req (t_req_item)
//  result  | out | o_rsp_valid / i_rsp_ready  | o_rsp (t_rsp_item)
//
// One request at a time. A token walks the level cells one level per cycle, each level a RAM.
// Push: one insert walk down the levels, none on an empty or full heap.
// Pop: a fetch walk then a sift walk, neither for one entry or an empty heap.
// LEVELS = clog2(HEAP_DEPTH+1) - 1; 10 at the default depth.
// Reset clears state, count, error and result valid; root and level RAMs need no clearing.
// Results wait in the output register; a second result behind a stalled one blocks requests.
module binary_min_heap_queue_top
    import bmhq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_ready,
    input  t_req_item i_req,
    output logic      o_rsp_valid,
    input  logic      i_rsp_ready,
    output t_rsp_item o_rsp
);

    localparam int CW    = $clog2(HEAP_DEPTH + 1);
    localparam int NCELL = $clog2(HEAP_DEPTH + 1) - 1;

    function automatic logic [DEP_W-1:0] msb_pos(input logic [NODE_W-1:0] x);
        logic [DEP_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < NODE_W; i++) begin
            if (x[i]) begin
                pos = DEP_W'(i);
            end
        end
        return pos;
    endfunction

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic signed [VAL_W-1:0] r_root;
    logic signed [VAL_W-1:0] n_root;
    logic                    r_err;
    logic                    n_err;
    logic                    r_rsp_valid;
    t_rsp_item               r_rsp;
    t_rsp_item               rsp_d;
    logic                    rsp_load;

    t_tok                    tok [NCELL+1];
    t_upw                    upw [1:NCELL+1];
    t_tok                    l_tok;

    logic                    req_fire;
    logic                    heap_full;
    logic                    heap_empty;
    logic                    pop_one;
    logic [CW-1:0]           cnt_inc;
    logic [NODE_W-1:0]       ins_tgt;
    logic [DEP_W-1:0]        ins_dep;
    logic [NODE_W-1:0]       pop_tgt;
    logic [DEP_W-1:0]        pop_dep;
    logic [CW+CNT_OUT_W-1:0] cnt_wide;

    assign req_fire   = i_req_valid && o_req_ready;
    assign heap_full  = r_count == CW'(HEAP_DEPTH);
    assign heap_empty = r_count == '0;
    assign pop_one    = r_count == CW'(1);
    assign cnt_inc    = r_count + CW'(1);
    assign ins_tgt    = NODE_W'(cnt_inc);
    assign ins_dep    = msb_pos(ins_tgt);
    assign pop_tgt    = NODE_W'(r_count);
    assign pop_dep    = msb_pos(pop_tgt);
    assign rsp_load   = (r_state == ST_DONE) && (!r_rsp_valid || i_rsp_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.req_type == REQ_PUSH) begin
                        n_state = (heap_full || ins_dep == '0) ? ST_DONE : ST_INS;
                    end else begin
                        n_state = (heap_empty || pop_one) ? ST_DONE : ST_FETCH;
                    end
                end
            end
            ST_INS:   if (tok[NCELL].act) n_state = ST_DONE;
            ST_FETCH: if (tok[NCELL].act) n_state = ST_SIFT;
            ST_SIFT:  if (tok[NCELL].act) n_state = ST_DONE;
            ST_DONE:  if (rsp_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_root  = r_root;
        n_err   = r_err;
        l_tok   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_err = 1'b0;
                    if (i_req.req_type == REQ_PUSH) begin
                        if (heap_full) begin
                            n_err = 1'b1;
                        end else begin
                            n_count = cnt_inc;
                            if (ins_dep == '0 || i_req.push_value < r_root) begin
                                n_root = i_req.push_value;
                            end
                            l_tok.act  = ins_dep != '0;
                            l_tok.op   = OP_INS;
                            l_tok.tgt  = ins_tgt;
                            l_tok.dep  = ins_dep;
                            l_tok.lim  = ins_tgt;
                            l_tok.node = NODE_W'(2) | NODE_W'(ins_tgt[ins_dep - DEP_W'(1)]);
                            l_tok.val  = (i_req.push_value < r_root) ? r_root
                                                                      : i_req.push_value;
                        end
                    end else begin
                        if (heap_empty) begin
                            n_err = 1'b1;
                        end else begin
                            n_count    = r_count - CW'(1);
                            l_tok.act  = !pop_one;
                            l_tok.op   = OP_FETCH;
                            l_tok.tgt  = pop_tgt;
                            l_tok.dep  = pop_dep;
                            l_tok.lim  = pop_tgt;
                            l_tok.node = NODE_W'(2) | NODE_W'(pop_tgt[pop_dep - DEP_W'(1)]);
                        end
                    end
                end
            end
            ST_FETCH: begin
                if (tok[NCELL].act) begin
                    l_tok.act  = 1'b1;
                    l_tok.op   = OP_SIFT;
                    l_tok.node = NODE_W'(2);
                    l_tok.lim  = NODE_W'(r_count);
                    l_tok.val  = tok[NCELL].val;
                end
            end
            ST_SIFT: begin
                if (upw[1].we) begin
                    n_root = upw[1].val;
                end
            end
            ST_INS, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign tok[0]         = l_tok;
    assign upw[NCELL + 1] = '0;

    for (genvar k = 1; k <= NCELL; k++) begin : g_cell
        bmhq_cell #(
            .LVL (k),
            .LAST(k == NCELL)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (tok[k-1]),
            .o_tok  (tok[k]),
            .i_upw  (upw[k+1]),
            .o_upw  (upw[k])
        );
    end

    assign cnt_wide = {{CNT_OUT_W{1'b0}}, r_count};

    always_comb begin
        rsp_d.min_value   = heap_empty ? {VAL_W{1'b1}} : r_root;
        rsp_d.entry_count = cnt_wide[CNT_OUT_W-1:0];
        rsp_d.is_empty    = heap_empty;
        rsp_d.op_error    = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= n_root;
        if (rsp_load) begin
            r_rsp <= rsp_d;
        end
    end

    assign o_req_ready = r_state == ST_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_exit_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[NCELL].act |-> (r_state == ST_INS || r_state == ST_FETCH || r_state == ST_SIFT))
        else $error("token left the chain outside a walk");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HEAP_DEPTH))
        else $error("entry count beyond heap depth");

    a_full_push_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_req.req_type == REQ_PUSH && heap_full) |=> $stable(r_count) && r_err)
        else $error("push on full heap changed the count");

    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.is_empty) |-> (o_rsp.min_value == {VAL_W{1'b1}}))
        else $error("empty heap reported a minimum");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the binary min-heap queue: directed, fill, stall and random.
module testbench
    import bmhq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH    = HEAP_DEPTH_DEF;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DEEP_ITEMS    = 160;
    localparam int RANDOM_ITEMS  = 140;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = 50;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_req_valid = 1'b0;
    logic      o_req_ready;
    t_req_item i_req = '0;
    logic      o_rsp_valid;
    logic      i_rsp_ready = 1'b0;
    t_rsp_item o_rsp;

    // heap predictor state
    logic signed [VAL_W-1:0] heap_model [HEAP_DEPTH];
    int                      heap_fill = 0;

    t_rsp_item expected_results [$];
    int        mismatch_count = 0;
    int        rsp_hold_request = 0;

    binary_min_heap_queue_top #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void swap_slots(int a, int b);
        logic signed [VAL_W-1:0] tmp;
        tmp           = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = tmp;
    endfunction

    function automatic t_rsp_item predict_heap_result(t_req_item item);
        t_rsp_item res;
        int        pos;
        int        par;
        int        pick;
        logic      err;
        logic      done;
        err  = 1'b0;
        done = 1'b0;
        if (item.req_type == REQ_PUSH) begin
            if (heap_fill >= HEAP_DEPTH) begin
                err = 1'b1;
            end else begin
                heap_model[heap_fill] = item.push_value;
                heap_fill++;
                pos = heap_fill - 1;
                while (pos > 0 && !done) begin
                    par = (pos - 1) / 2;
                    if (heap_model[pos] >= heap_model[par]) begin
                        done = 1'b1;
                    end else begin
                        swap_slots(pos, par);
                        pos = par;
                    end
                end
            end
        end else begin
            if (heap_fill == 0) begin
                err = 1'b1;
            end else begin
                heap_model[0] = heap_model[heap_fill - 1];
                heap_fill--;
                pos = 0;
                while (2 * pos + 1 < heap_fill && !done) begin
                    pick = 2 * pos + 1;
                    // left child wins a tie
                    if (pick + 1 < heap_fill && heap_model[pick + 1] < heap_model[pick])
                        pick = pick + 1;
                    if (heap_model[pos] < heap_model[pick]) begin
                        done = 1'b1;
                    end else begin
                        swap_slots(pos, pick);
                        pos = pick;
                    end
                end
            end
        end
        res.min_value   = (heap_fill > 0) ? heap_model[0] : -32'sd1;
        res.entry_count = CNT_OUT_W'(heap_fill);
        res.is_empty    = (heap_fill == 0);
        res.op_error    = err;
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = -32'sd1;
                    default: v = 32'sd0;
                endcase
            end
            1, 2: v = $signed($urandom_range(0, 15)) - 32'sd8;
            default: v = $signed($urandom);
        endcase
        return v;
    endfunction

    // one request: hold valid until accepted, predict at acceptance
    task automatic send_request(t_req req, logic signed [VAL_W-1:0] value);
        t_req_item item;
        t_rsp_item want;
        item.req_type   = req;
        item.push_value = value;
        @(negedge i_clk);
        i_req_valid = 1'b1;
        i_req       = item;
        do @(posedge i_clk); while (!o_req_ready);
        want             = predict_heap_result(item);
        expected_results = {expected_results, want};
    endtask

    task automatic sender_gap(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_req_valid = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drain();
        sender_gap(1);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern, with a long hold when asked
    initial begin
        int hold_left;
        int seg_left;
        int seg_mode;
        hold_left = 0;
        seg_left  = 0;
        seg_mode  = 0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_request != 0) begin
                hold_left        = HOLD_CYCLES;
                rsp_hold_request = 0;
            end
            if (hold_left > 0) begin
                i_rsp_ready = 1'b0;
                hold_left--;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 40);
                    seg_mode = $urandom_range(0, 3);
                end
                seg_left--;
                case (seg_mode)
                    0: i_rsp_ready = 1'b1;
                    1: i_rsp_ready = $urandom_range(0, 1);
                    2: i_rsp_ready = ($urandom_range(0, 3) != 0);
                    default: i_rsp_ready = 1'b0;
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_rsp_item want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: min=%0d cnt=%0d empty=%0b err=%0b",
                             o_rsp.min_value, o_rsp.entry_count, o_rsp.is_empty,
                             o_rsp.op_error);
            end else begin
                want = expected_results.pop_front();
                if (o_rsp.min_value !== want.min_value ||
                    o_rsp.entry_count !== want.entry_count ||
                    o_rsp.is_empty !== want.is_empty ||
                    o_rsp.op_error !== want.op_error) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 want.min_value, want.entry_count, want.is_empty,
                                 want.op_error, o_rsp.min_value, o_rsp.entry_count,
                                 o_rsp.is_empty, o_rsp.op_error);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic test_directed();
        send_request(REQ_POP, 32'sd0);           // pop on empty heap
        send_request(REQ_PUSH, 32'sh7fff_ffff);
        send_request(REQ_PUSH, 32'sh8000_0000);
        send_request(REQ_PUSH, -32'sd1);
        send_request(REQ_PUSH, 32'sd0);
        send_request(REQ_POP, 32'sh7fff_ffff);   // value ignored on pop
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);           // empty again
        // equal keys through sift-down
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sd3);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sd3);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        wait_drain();
    endtask

    // fill several levels deep, then drain past empty
    task automatic test_deep_fill();
        repeat (DEEP_ITEMS) send_request(REQ_PUSH, rand_value());
        repeat (DEEP_ITEMS + 1) send_request(REQ_POP, rand_value());
        wait_drain();
    endtask

    task automatic test_backpressure();
        rsp_hold_request = 1;
        repeat (16) send_request($urandom_range(0, 2) != 0 ? REQ_PUSH : REQ_POP, rand_value());
        wait_drain();
    endtask

    task automatic test_random();
        int  sent;
        int  burst;
        int  push_pct;
        logic growing;
        sent    = 0;
        growing = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                if ($urandom_range(0, 59) == 0)
                    growing = ~growing;
                push_pct = growing ? 70 : 30;
                if ($urandom_range(0, 99) < push_pct)
                    send_request(REQ_PUSH, rand_value());
                else
                    send_request(REQ_POP, rand_value());
                sent++;
            end
            sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        wait_drain();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);
        test_directed();
        test_deep_fill();
        test_backpressure();
        test_random();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_cell.sv
rtl/binary_min_heap_queue_top.sv
sim/testbench.sv
